[rtl/amrc_pkg.sv]
package amrc_pkg;

    // Input item layout on s_axis_tdata, from the lowest bit up
    localparam int IN_DATA_W   = 192;
    localparam int OUT_DATA_W  = 40;

    localparam int RIDX_LSB    = 0;
    localparam int RAPP_LSB    = 6;
    localparam int RCLS_LSB    = 21;
    localparam int RMAC_LSB    = 29;
    localparam int RANY_LSB    = 77;
    localparam int CMARK_LSB   = 78;
    localparam int CMAC_LSB    = 110;
    localparam int CFOUND_LSB  = 158;
    localparam int PMARK_LSB   = 159;

    localparam int COUNT_W     = 7;

    // Item kinds carried on s_axis_tuser
    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    // Result status codes carried on m_axis_tuser
    localparam logic [1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [1:0] STATUS_MATCHED = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH = 2'd2;
    localparam logic [1:0] STATUS_SKIPPED = 2'd3;

    // Result selection from controller to datapath
    localparam logic [1:0] RES_WRITE   = 2'd0;
    localparam logic [1:0] RES_SKIP    = 2'd1;
    localparam logic [1:0] RES_MATCH   = 2'd2;
    localparam logic [1:0] RES_NOMATCH = 2'd3;

    // Application id handling
    localparam logic [31:0] APP_ID_MASK = 32'h0000FFFF;
    localparam logic [15:0] APP_ID_MAX  = 16'd32000;

    typedef struct packed {
        logic        any_mac;
        logic [47:0] mac;
        logic [7:0]  class_code;
        logic [14:0] app_id;
    } rule_t;

    typedef struct packed {
        logic       capture;
        logic       we;
        logic       rd_en;
        logic       res_load;
        logic [1:0] res_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic skip;
        logic idx_ok;
        logic match;
    } stat_t;

endpackage

[rtl/app_mac_rule_classifier.sv]
// First-match QoS classifier over a rule table of RULES entries. A rule write
// item (tuser 0) stores one entry and returns status 0; a classify item
// (tuser 1) takes the application id from the low 16 bits of conn_mark and,
// unless the id is 0, above 32000 or no client was found (status 3, mark
// unchanged), scans entries 0 to min(rule_count, RULES)-1 for the first one
// whose id matches and whose MAC equals host_mac or is a wildcard. The class
// field of the mark (CLASS_BITS bits at CLASS_SHIFT) is cleared and set to the
// matched class. Rules sit in a single-port table read once per cycle, one
// entry per read; a scan ends at the first match or after the last searched
// entry, and writes, skipped packets and an empty search read no entry at all.
// The next item is taken only after the result has moved into the output
// register, so the block handles one item at a time.
// Entries must be written before rule_count covers them: the table has no
// reset.
module app_mac_rule_classifier #(
    parameter int RULES       = 64,
    parameter int CLASS_SHIFT = 16,
    parameter int CLASS_BITS  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // rule_index, rule_app_id, rule_class, rule_mac, rule_any_mac, conn_mark,
    // host_mac, client_found, pkt_mark, one zero pad bit
    input  logic [amrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // new_mark, class_out
    output logic [amrc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [1:0]                         m_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    // rule_count
    input  logic [amrc_pkg::COUNT_W-1:0]       cfg_data
);

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;

    amrc_pkg::cmd_t   cmd;
    amrc_pkg::stat_t  stat;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      new_mark;
    logic [7:0]       class_out;

    amrc_ctrl #(
        .RULES (RULES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    amrc_datapath #(
        .RULES       (RULES),
        .CLASS_SHIFT (CLASS_SHIFT),
        .CLASS_BITS  (CLASS_BITS)
    ) u_datapath (
        .clk       (clk),
        .in_data   (s_axis_tdata),
        .in_mode   (s_axis_tuser),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .stat      (stat),
        .new_mark  (new_mark),
        .class_out (class_out),
        .status    (m_axis_tuser)
    );

    assign m_axis_tdata = {class_out, new_mark};

endmodule

[rtl/amrc_datapath.sv]
module amrc_datapath #(
    parameter int RULES       = 64,
    parameter int CLASS_SHIFT = 16,
    parameter int CLASS_BITS  = 8,
    localparam int IDX_W      = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  logic                             clk,
    input  logic [amrc_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                             in_mode,
    input  amrc_pkg::cmd_t                   cmd,
    input  logic [IDX_W-1:0]                 rd_addr,
    output amrc_pkg::stat_t                  stat,
    output logic [31:0]                      new_mark,
    output logic [7:0]                       class_out,
    output logic [1:0]                       status
);

    localparam logic [31:0] CLASS_MASK =
        32'(((64'd1 << CLASS_BITS) - 64'd1) << CLASS_SHIFT);

    // Captured item
    logic                 mode_reg;
    logic [5:0]           idx_reg;
    amrc_pkg::rule_t      wr_rule_reg;
    logic [31:0]          conn_mark_reg;
    logic [47:0]          host_mac_reg;
    logic                 client_found_reg;
    logic [31:0]          pkt_mark_reg;

    // Rule table and its registered read port
    amrc_pkg::rule_t      mem [RULES];
    amrc_pkg::rule_t      rd_data_reg;

    // Pending result and output register
    logic [31:0]          res_mark_reg;
    logic [7:0]           res_class_reg;
    logic [1:0]           res_status_reg;
    logic [31:0]          out_mark_reg;
    logic [7:0]           out_class_reg;
    logic [1:0]           out_status_reg;

    logic [15:0]          app_id;
    logic [31:0]          cleared_mark;
    logic [31:0]          enc_class;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg               <= in_mode;
            idx_reg                <= in_data[amrc_pkg::RIDX_LSB +: 6];
            wr_rule_reg.app_id     <= in_data[amrc_pkg::RAPP_LSB +: 15];
            wr_rule_reg.class_code <= in_data[amrc_pkg::RCLS_LSB +: 8];
            wr_rule_reg.mac        <= in_data[amrc_pkg::RMAC_LSB +: 48];
            wr_rule_reg.any_mac    <= in_data[amrc_pkg::RANY_LSB];
            conn_mark_reg          <= in_data[amrc_pkg::CMARK_LSB +: 32];
            host_mac_reg           <= in_data[amrc_pkg::CMAC_LSB +: 48];
            client_found_reg       <= in_data[amrc_pkg::CFOUND_LSB];
            pkt_mark_reg           <= in_data[amrc_pkg::PMARK_LSB +: 32];
        end
    end

    // Write one rule, read one rule per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[IDX_W'(idx_reg)] <= wr_rule_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign app_id       = 16'(conn_mark_reg & amrc_pkg::APP_ID_MASK);
    assign cleared_mark = pkt_mark_reg & ~CLASS_MASK;
    assign enc_class    = (32'(rd_data_reg.class_code) << CLASS_SHIFT) & CLASS_MASK;

    // Status back to the controller
    always_comb
    begin
        stat.mode   = mode_reg;
        stat.skip   = (app_id == 16'd0) || (app_id > amrc_pkg::APP_ID_MAX) ||
                      !client_found_reg;
        stat.idx_ok = (32'(idx_reg) < RULES);
        stat.match  = ({1'b0, rd_data_reg.app_id} == app_id) &&
                      (rd_data_reg.any_mac || (rd_data_reg.mac == host_mac_reg));
    end

    // Form the result
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                amrc_pkg::RES_WRITE:
                begin
                    res_mark_reg   <= 32'd0;
                    res_class_reg  <= 8'd0;
                    res_status_reg <= amrc_pkg::STATUS_WRITTEN;
                end
                amrc_pkg::RES_SKIP:
                begin
                    res_mark_reg   <= pkt_mark_reg;
                    res_class_reg  <= 8'd0;
                    res_status_reg <= amrc_pkg::STATUS_SKIPPED;
                end
                amrc_pkg::RES_MATCH:
                begin
                    res_class_reg <= rd_data_reg.class_code;
                    if (rd_data_reg.class_code != 8'd0)
                    begin
                        res_mark_reg   <= cleared_mark | enc_class;
                        res_status_reg <= amrc_pkg::STATUS_MATCHED;
                    end
                    else
                    begin
                        res_mark_reg   <= cleared_mark;
                        res_status_reg <= amrc_pkg::STATUS_NOMATCH;
                    end
                end
                default:
                begin
                    res_mark_reg   <= cleared_mark;
                    res_class_reg  <= 8'd0;
                    res_status_reg <= amrc_pkg::STATUS_NOMATCH;
                end
            endcase
        end
    end

    // Hand the result to the output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mark_reg   <= res_mark_reg;
            out_class_reg  <= res_class_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign new_mark  = out_mark_reg;
    assign class_out = out_class_reg;
    assign status    = out_status_reg;

endmodule

[rtl/amrc_ctrl.sv]
module amrc_ctrl #(
    parameter int RULES  = 64,
    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1,
    localparam int CNT_W = IDX_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [amrc_pkg::COUNT_W-1:0]  cfg_data,
    input  amrc_pkg::stat_t               stat,
    output amrc_pkg::cmd_t                cmd,
    output logic [IDX_W-1:0]              rd_addr
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             issue_cnt_reg, issue_cnt_next;
    logic                         pend_reg, pend_next;
    logic                         out_valid_reg, out_valid_next;
    logic [amrc_pkg::COUNT_W-1:0] rule_count_reg;
    logic [CNT_W-1:0]             limit;
    logic                         hit;

    // Clamp the search length to the table size
    assign limit = (32'(rule_count_reg) > RULES) ? CNT_W'(RULES) : CNT_W'(rule_count_reg);
    assign hit   = pend_reg && stat.match;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;
    assign rd_addr   = IDX_W'(issue_cnt_reg);

    // Hold the rule count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            rule_count_reg <= cfg_data;
        end
    end

    // Sequence one item
    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.res_load   = 1'b1;
                issue_cnt_next = '0;
                state_next     = S_DONE;
                if (stat.mode == amrc_pkg::MODE_WRITE)
                begin
                    cmd.we      = stat.idx_ok;
                    cmd.res_sel = amrc_pkg::RES_WRITE;
                end
                else if (stat.skip)
                begin
                    cmd.res_sel = amrc_pkg::RES_SKIP;
                end
                else if (limit == '0)
                begin
                    cmd.res_sel = amrc_pkg::RES_NOMATCH;
                end
                else
                begin
                    cmd.res_load = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = amrc_pkg::RES_MATCH;
                    state_next   = S_DONE;
                end
                else if (issue_cnt_reg < limit)
                begin
                    cmd.rd_en      = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    pend_next      = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = amrc_pkg::RES_NOMATCH;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Reads stay inside the searched range
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (issue_cnt_reg < limit))
        else $error("rule read beyond the search limit");

    // A hit ends the search at once
    a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && hit |=> (state_reg == S_DONE))
        else $error("search continued past a matching rule");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten while still waiting");

    // Table writes come only from a rule write item
    a_we_write_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.we |-> (state_reg == S_PREP) && (stat.mode == amrc_pkg::MODE_WRITE))
        else $error("table written outside a rule write");

    // An accepted item is examined in the next cycle
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == S_PREP))
        else $error("accepted item not examined");

endmodule
